// File: rtl/core/nrd_pkg.sv
// Shared types and constants for the 96-bit non-restoring divider.
// No dependencies; used by every module in rtl/core.
package nrd_pkg;

   // Width of the split operand fields as they appear on the ports
   localparam int unsigned FIELD_LOW_BITS  = 64;
   localparam int unsigned FIELD_HIGH_BITS = 32;
   localparam int unsigned FIELD_BITS      = FIELD_LOW_BITS + FIELD_HIGH_BITS;

   // Per-cycle command to the row of cells
   typedef struct packed {
      logic load;  // capture a new beat
      logic step;  // shift and add/subtract
      logic fix;   // final add-back of the divisor
   } cell_op_type;

endpackage

// File: rtl/core/nrd_cell.sv
// One bit slice of the divider: a partial remainder bit, a quotient bit
// and a divisor bit, with a full adder. Depends on nrd_pkg.
module nrd_cell (
   input  logic                clock,
   input  nrd_pkg::cell_op_type op,
   input  logic                subtract,
   input  logic                p_shift_in,
   input  logic                a_shift_in,
   input  logic                carry_in,
   input  logic                p_load,
   input  logic                a_load,
   input  logic                d_load,
   output logic                p_out,
   output logic                a_out,
   output logic                sum_out,
   output logic                carry_out
);

   logic p_ff, p_in;
   logic a_ff, a_in;
   logic d_ff, d_in;
   logic x, y;

   // step uses the remainder shifted left; fix adds in place
   assign x         = op.fix ? p_ff : p_shift_in;
   assign y         = op.fix ? d_ff : (d_ff ^ subtract);
   assign sum_out   = x ^ y ^ carry_in;
   assign carry_out = (x & y) | (x & carry_in) | (y & carry_in);

   always_comb begin
      p_in = p_ff;
      a_in = a_ff;
      d_in = d_ff;
      if (op.load) begin
         p_in = p_load;
         a_in = a_load;
         d_in = d_load;
      end else if (op.step) begin
         p_in = sum_out;
         a_in = a_shift_in;
      end else if (op.fix) begin
         p_in = sum_out;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      a_ff <= a_in;
      d_ff <= d_in;
   end

   assign p_out = p_ff;
   assign a_out = a_ff;

endmodule

// File: rtl/core/nrd_ctrl.sv
// Sequencer for the divider: load, one step per quotient bit, add-back,
// result beat. Depends on nrd_pkg.
module nrd_ctrl #(
   parameter int unsigned OPERAND_WIDTH = 96
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 done,
   output nrd_pkg::cell_op_type op
);

   localparam int unsigned CNT_BITS = $clog2(OPERAND_WIDTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               count_in = CNT_BITS'(OPERAND_WIDTH - 1);
            end
         end
         ST_RUN: begin
            if (count_ff == '0) begin
               state_in = ST_FIX;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_FIX:  state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign done    = (state_ff == ST_DONE);
   assign op.load = start && (state_ff == ST_IDLE);
   assign op.step = (state_ff == ST_RUN);
   assign op.fix  = (state_ff == ST_FIX);

endmodule

// File: rtl/core/nonrestoring_divider_96.sv
// Unsigned non-restoring divider over a row of OPERAND_WIDTH+1 bit cells.
// From accepted req beat to rsp strobe: load on the accepting edge, one
// add/subtract step per quotient bit through the cell row's ripple carry,
// an add-back state that adds the divisor back only if the remainder is negative, then the strobe.
// A new beat is taken only once the sequencer is idle again; busy spans the strobe.
// Reset (synchronous) returns the sequencer to idle; the receiver cannot stall.
module nonrestoring_divider_96 #(
   parameter int unsigned OPERAND_WIDTH = 96
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_dividend_low,
   input  logic [31:0] req_dividend_high,
   input  logic [63:0] req_divisor_low,
   input  logic [31:0] req_divisor_high,
   output logic        rsp_valid,
   output logic [63:0] rsp_quotient_low,
   output logic [31:0] rsp_quotient_high,
   output logic [63:0] rsp_remainder_low,
   output logic [31:0] rsp_remainder_high,
   output logic        rsp_divide_by_zero
);

   localparam int unsigned W  = OPERAND_WIDTH;
   localparam int unsigned FB = nrd_pkg::FIELD_BITS;
   localparam int unsigned LB = nrd_pkg::FIELD_LOW_BITS;

   nrd_pkg::cell_op_type ctrl_op;
   nrd_pkg::cell_op_type cell_op;

   logic [FB-1:0] dividend_field, divisor_field;
   logic [W-1:0]  dividend_op, divisor_op;
   logic [W-1:0]  quotient_op, remainder_op;
   logic [FB-1:0] quotient_field, remainder_field;

   // Cell row: bit W of the partial remainder is the extra sign bit
   logic [W:0]    p_bit, a_bit, sum_bit;
   logic [W+1:0]  carry;
   logic          sign, subtract;

   logic dbz_ff, dbz_in;

   assign dividend_field = {req_dividend_high, req_dividend_low};
   assign divisor_field  = {req_divisor_high, req_divisor_low};

   // Cut or zero-extend the port fields to the operand width
   generate
      if (W <= FB) begin : g_in_narrow
         assign dividend_op = dividend_field[W-1:0];
         assign divisor_op  = divisor_field[W-1:0];
      end else begin : g_in_wide
         assign dividend_op = {{(W-FB){1'b0}}, dividend_field};
         assign divisor_op  = {{(W-FB){1'b0}}, divisor_field};
      end
   endgenerate

   nrd_ctrl #(
      .OPERAND_WIDTH(W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .done (rsp_valid),
      .op   (ctrl_op)
   );

   // Sign of the partial remainder picks subtract or add; add-back only
   // when the final remainder is negative
   assign sign     = p_bit[W];
   assign subtract = ~sign;
   assign cell_op  = '{load: ctrl_op.load,
                       step: ctrl_op.step,
                       fix:  ctrl_op.fix & sign};
   assign carry[0] = ctrl_op.step & subtract;

   generate
      for (genvar i = 0; i <= W; i++) begin : g_cell
         logic p_shift, a_shift, p_ld, a_ld, d_ld;
         if (i == 0) begin : g_lsb
            // dividend's top bit shifts into the remainder, new quotient
            // bit is the inverted sign of the step result
            assign p_shift = a_bit[W-1];
            assign a_shift = ~sum_bit[W];
         end else begin : g_mid
            assign p_shift = p_bit[i-1];
            assign a_shift = (i < W) ? a_bit[i-1] : 1'b0;
         end
         if (i < W) begin : g_data
            assign a_ld = dividend_op[i];
            assign d_ld = divisor_op[i];
         end else begin : g_sign
            assign a_ld = 1'b0;
            assign d_ld = 1'b0;
         end
         assign p_ld = 1'b0;

         nrd_cell u_cell (
            .clock     (clock),
            .op        (cell_op),
            .subtract  (subtract),
            .p_shift_in(p_shift),
            .a_shift_in(a_shift),
            .carry_in  (carry[i]),
            .p_load    (p_ld),
            .a_load    (a_ld),
            .d_load    (d_ld),
            .p_out     (p_bit[i]),
            .a_out     (a_bit[i]),
            .sum_out   (sum_bit[i]),
            .carry_out (carry[i+1])
         );
      end
   endgenerate

   // Zero divisor flag, captured with the beat
   assign dbz_in = ctrl_op.load ? ~|divisor_op : dbz_ff;

   always_ff @(posedge clock) begin
      dbz_ff <= dbz_in;
   end

   // A zero divisor leaves the dividend in the remainder; quotient forced
   assign quotient_op  = dbz_ff ? '0 : a_bit[W-1:0];
   assign remainder_op = p_bit[W-1:0];

   generate
      if (W >= FB) begin : g_out_wide
         assign quotient_field  = quotient_op[FB-1:0];
         assign remainder_field = remainder_op[FB-1:0];
      end else begin : g_out_narrow
         assign quotient_field  = {{(FB-W){1'b0}}, quotient_op};
         assign remainder_field = {{(FB-W){1'b0}}, remainder_op};
      end
   endgenerate

   assign rsp_quotient_low   = quotient_field[LB-1:0];
   assign rsp_quotient_high  = quotient_field[FB-1:LB];
   assign rsp_remainder_low  = remainder_field[LB-1:0];
   assign rsp_remainder_high = remainder_field[FB-1:LB];
   assign rsp_divide_by_zero = dbz_ff;

   // A result beat only ever comes out of a busy block
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("rsp beat while idle");

   // Each result is a single-cycle strobe
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp strobe longer than one cycle");

   // An accepted beat makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start the sequence");

   // Division by zero returns a zero quotient
   a_dbz_quot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (rsp_quotient_low == '0 && rsp_quotient_high == '0))
      else $error("non-zero quotient on division by zero");

endmodule

// File: bench/tb_nonrestoring_divider_96.sv
// Self-checking bench for the 96-bit unsigned non-restoring divider.
// Depends on rtl/core/nrd_pkg.sv and rtl/core/nonrestoring_divider_96.sv; reads no files.
// Quotient, remainder and the divide-by-zero flag are predicted per beat and checked in order.
module tb_nonrestoring_divider_96;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FIELD_LOW_BITS  = nrd_pkg::FIELD_LOW_BITS;
   localparam int unsigned FIELD_HIGH_BITS = nrd_pkg::FIELD_HIGH_BITS;
   localparam int unsigned FIELD_BITS      = nrd_pkg::FIELD_BITS;

   localparam int unsigned OPERAND_WIDTH = 96;
   // Accepted beat to rsp strobe, in clock cycles
   localparam int unsigned LATENCY       = OPERAND_WIDTH + 2;
   localparam int unsigned HALF_PERIOD   = 5;
   localparam int unsigned RESET_CYCLES  = 7;
   localparam int unsigned RANDOM_BEATS  = 1400;
   // Watchdog bound, sized for the longest gaps plus a full sequence per beat
   localparam int unsigned CYCLE_LIMIT   = 1_500_000;
   // Sender inserts no random gaps while beats_sent lies in [QUIET_FROM, QUIET_TO)
   localparam int unsigned QUIET_FROM    = 400;
   localparam int unsigned QUIET_TO      = 700;
   localparam int unsigned IDLE_PERCENT  = 11;
   localparam int unsigned MAX_GAP       = 130;

   // Inputs above OPERAND_WIDTH are ignored by the block
   localparam logic [FIELD_BITS-1:0] OPERAND_MASK = (OPERAND_WIDTH >= FIELD_BITS) ?
                                                    {FIELD_BITS{1'b1}} :
                                                    ~({FIELD_BITS{1'b1}} << OPERAND_WIDTH);

   typedef struct packed {
      logic [FIELD_BITS-1:0] dividend;
      logic [FIELD_BITS-1:0] divisor;
      logic                  drain_before;  // hold off until every result is back
   } operand_pair_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] quotient;
      logic [FIELD_BITS-1:0] remainder;
      logic                  divide_by_zero;
   } division_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [FIELD_LOW_BITS-1:0]  req_dividend_low;
   logic [FIELD_HIGH_BITS-1:0] req_dividend_high;
   logic [FIELD_LOW_BITS-1:0]  req_divisor_low;
   logic [FIELD_HIGH_BITS-1:0] req_divisor_high;
   logic                       rsp_valid;
   logic [FIELD_LOW_BITS-1:0]  rsp_quotient_low;
   logic [FIELD_HIGH_BITS-1:0] rsp_quotient_high;
   logic [FIELD_LOW_BITS-1:0]  rsp_remainder_low;
   logic [FIELD_HIGH_BITS-1:0] rsp_remainder_high;
   logic                       rsp_divide_by_zero;

   operand_pair_type pending_operands[$];    // filled up front, drained by the driver
   division_type     expected_divisions[$];  // one per accepted beat, oldest first

   logic req_taken      = 1'b0;  // the last rising edge accepted a beat
   int   gap_left       = 0;
   int   beats_sent     = 0;
   int   results_seen   = 0;
   int   mismatch_count = 0;
   int   cycle_count    = 0;

   nonrestoring_divider_96 #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend_low   (req_dividend_low),
      .req_dividend_high  (req_dividend_high),
      .req_divisor_low    (req_divisor_low),
      .req_divisor_high   (req_divisor_high),
      .rsp_valid          (rsp_valid),
      .rsp_quotient_low   (rsp_quotient_low),
      .rsp_quotient_high  (rsp_quotient_high),
      .rsp_remainder_low  (rsp_remainder_low),
      .rsp_remainder_high (rsp_remainder_high),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Position of the leading one; callers never pass zero
   function automatic int top_bit(logic [FIELD_BITS-1:0] value);
      int pos;
      pos = -1;
      for (int k = 0; k < FIELD_BITS; k++)
         if (value[k]) pos = k;
      return pos;
   endfunction

   // Non-restoring division, step for step. The partial remainder is kept
   // in 128 signed bits: the aligned divisor is below 2^96 and the doubled
   // remainder below 2^97, so the sign bit never overflows.
   function automatic division_type divide_operands(logic [FIELD_BITS-1:0] dividend,
                                                    logic [FIELD_BITS-1:0] divisor);
      division_type        res;
      logic signed [127:0] partial;
      logic signed [127:0] aligned;
      logic [FIELD_BITS-1:0] num;
      logic [FIELD_BITS-1:0] den;
      int                shift;
      int                bit_pos;
      res = '0;
      num = dividend & OPERAND_MASK;
      den = divisor & OPERAND_MASK;
      if (den == '0) begin
         res.divide_by_zero = 1'b1;
         res.remainder      = num;
      end else if (num < den) begin
         // covers a zero dividend too
         res.remainder = num;
      end else begin
         shift   = top_bit(num) - top_bit(den);
         aligned = 128'(den) << shift;
         partial = 128'(num);
         for (bit_pos = shift; bit_pos >= 0; bit_pos--) begin
            if (partial < 0) partial = partial + aligned;
            else             partial = partial - aligned;
            res.quotient = {res.quotient[FIELD_BITS-2:0], ~partial[127]};
            if (bit_pos > 0) partial = partial <<< 1;
         end
         // add-back for a negative final remainder, then undo the alignment
         if (partial < 0) partial = partial + aligned;
         res.remainder = FIELD_BITS'(partial >> shift);
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Reporting
   // ------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [FIELD_LOW_BITS-1:0] got,
                              logic [FIELD_LOW_BITS-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [FIELD_BITS-1:0] random_word();
      return {$urandom, $urandom, $urandom};
   endfunction

   // Random value whose leading one sits at bit nbits-1; zero for nbits 0
   function automatic logic [FIELD_BITS-1:0] random_bits(int nbits);
      logic [FIELD_BITS-1:0] value;
      if (nbits <= 0) return '0;
      value = random_word() >> (FIELD_BITS - nbits);
      value[nbits-1] = 1'b1;
      return value;
   endfunction

   task automatic add_beat(logic [FIELD_BITS-1:0] dividend, logic [FIELD_BITS-1:0] divisor,
                           logic drain_before = 1'b0);
      operand_pair_type beat;
      beat.dividend     = dividend;
      beat.divisor      = divisor;
      beat.drain_before = drain_before;
      pending_operands.push_back(beat);
   endtask

   // ------------------------------------------------------------------
   // Driver: works on the falling edge so nothing races the block's
   // rising-edge sampling. start is held until the beat is taken, and
   // each signal gets one nonblocking write per edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      operand_pair_type beat;
      logic             raise;
      raise = 1'b0;
      if (reset) begin
         raise = 1'b0;
      end else if (start && !req_taken) begin
         raise = 1'b1;                       // beat still waiting on busy
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
      end else if (pending_operands.size() == 0) begin
         raise = 1'b0;
      end else if (pending_operands[0].drain_before &&
                   (expected_divisions.size() != 0 || busy)) begin
         raise = 1'b0;                       // let the pipe run dry first
      end else if (!(beats_sent >= QUIET_FROM && beats_sent < QUIET_TO) &&
                   $urandom_range(0, 99) < IDLE_PERCENT) begin
         // long enough gaps let start rise during, at and after the busy window
         gap_left = $urandom_range(1, MAX_GAP);
      end else begin
         beat = pending_operands.pop_front();
         req_dividend_low  <= beat.dividend[FIELD_LOW_BITS-1:0];
         req_dividend_high <= beat.dividend[FIELD_BITS-1:FIELD_LOW_BITS];
         req_divisor_low   <= beat.divisor[FIELD_LOW_BITS-1:0];
         req_divisor_high  <= beat.divisor[FIELD_BITS-1:FIELD_LOW_BITS];
         raise = 1'b1;
         beats_sent++;
      end
      start <= raise;
   end

   // ------------------------------------------------------------------
   // Monitor: rising edge. The result strobe is checked before any new
   // beat is predicted, so a stray strobe is never matched to the beat
   // taken on the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      division_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_divisions.size() == 0) begin
               report_mismatch("result strobe with no beat outstanding");
            end else begin
               want = expected_divisions.pop_front();
               check_field("quotient_low", rsp_quotient_low,
                           want.quotient[FIELD_LOW_BITS-1:0]);
               check_field("quotient_high", 64'(rsp_quotient_high),
                           64'(want.quotient[FIELD_BITS-1:FIELD_LOW_BITS]));
               check_field("remainder_low", rsp_remainder_low,
                           want.remainder[FIELD_LOW_BITS-1:0]);
               check_field("remainder_high", 64'(rsp_remainder_high),
                           64'(want.remainder[FIELD_BITS-1:FIELD_LOW_BITS]));
               check_field("divide_by_zero", 64'(rsp_divide_by_zero),
                           64'(want.divide_by_zero));
            end
            results_seen++;
         end
         req_taken <= start && !busy;
         if (start && !busy)
            expected_divisions.push_back(divide_operands(
               {req_dividend_high, req_dividend_low}, {req_divisor_high, req_divisor_low}));
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of test
   // ------------------------------------------------------------------
   initial begin
      logic [FIELD_BITS-1:0] num;
      logic [FIELD_BITS-1:0] den;
      logic [FIELD_BITS-1:0] ones;
      logic [FIELD_BITS-1:0] top_one;
      int                    pick;
      int                    len_num;

      ones    = '1;
      top_one = {1'b1, {(FIELD_BITS-1){1'b0}}};

      // Directed: zero divisor, zero dividend, dividend below divisor,
      // top-bit dividends, operands straddling the 64-bit boundary
      add_beat('0, '0);
      add_beat(ones, '0);
      add_beat('0, ones);
      add_beat(ones, ones);
      add_beat(ones, 96'd1);
      add_beat(96'd1, 96'd1);
      add_beat(96'd5, 96'd7);
      add_beat(top_one, 96'd3);
      add_beat(ones, top_one);
      add_beat(top_one | 96'd1, top_one);
      add_beat(ones, {32'h1, 64'h0});
      add_beat({32'h0, {64{1'b1}}}, {32'h1, 64'h0});
      add_beat(ones, {32'h0, {64{1'b1}}});
      add_beat(ones - 96'd1, ones);
      add_beat({48{2'b10}}, {48{2'b01}});
      add_beat({48{2'b01}}, {48{2'b10}});
      add_beat(96'h0123_4567_89ab_cdef_fedc_ba98, 96'd10);
      add_beat(ones, 96'd3);
      add_beat(top_one | 96'd1, 96'd2);
      add_beat(random_word(), '0, 1'b1);

      // Random: mostly dividend/divisor pairs of chosen bit lengths so that
      // the quotient length and the alignment shift spread over the range
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            num = random_word();
            den = random_word();
         end else if (pick < 60) begin
            len_num = $urandom_range(1, FIELD_BITS);
            num = random_bits(len_num);
            den = random_bits($urandom_range(1, len_num));
         end else if (pick < 70) begin
            // exact multiples: zero remainder
            den = random_bits($urandom_range(1, 48));
            num = den * random_bits($urandom_range(1, 48));
         end else if (pick < 78) begin
            // dividend at most the divisor
            num = random_word() >> $urandom_range(0, 95);
            den = random_word() >> $urandom_range(0, 95);
            if (num > den) {num, den} = {den, num};
         end else if (pick < 82) begin
            num = random_word();
            den = '0;
         end else if (pick < 88) begin
            num = random_bits($urandom_range(1, FIELD_BITS));
            den = ($urandom_range(0, 1) != 0) ? num : 96'd1;
         end else begin
            num = ($urandom_range(0, 3) == 0) ? ones : random_word();
            den = top_one >> $urandom_range(0, FIELD_BITS - 1);
         end
         add_beat(num, den, i == RANDOM_BEATS / 2);
      end

      start             = 1'b0;
      req_dividend_low  = '0;
      req_dividend_high = '0;
      req_divisor_low   = '0;
      req_divisor_high  = '0;
      reset             = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // All beats taken and every result back, then a grace period
      // for anything stray; the watchdog bounds both waits
      while (pending_operands.size() != 0 || start || expected_divisions.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/nrd_pkg.sv
rtl/core/nrd_cell.sv
rtl/core/nrd_ctrl.sv
rtl/core/nonrestoring_divider_96.sv
bench/tb_nonrestoring_divider_96.sv
